FILE: hdl/stereo_downmix_unit_macros.svh
// assertion macros for the stereo downmix unit
`ifndef STEREO_DOWNMIX_UNIT_MACROS_SVH
`define STEREO_DOWNMIX_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SDM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/sdm_pkg.sv
// types and constants shared by the stereo downmix unit and its checker
`timescale 1ns / 1ps

package sdm_pkg;

   typedef enum logic [1:0] {
      MODE_LEFT  = 2'd0,
      MODE_RIGHT = 2'd1,
      MODE_MEAN  = 2'd2,
      MODE_RMS   = 2'd3
   } mix_mode_type;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               block_end;
   } req_beat_type;

   typedef struct packed {
      logic signed [15:0] mono_sample;
      logic               block_end_out;
   } rsp_beat_type;

   localparam int SAMPLE_W    = 16;
   localparam int ROOT_W      = 16;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int REM_W       = ROOT_W + 3;
   localparam int SQRT_STAGES = ROOT_W / 2;
   // input, square, sum, root stages, output
   localparam int PIPE_LATENCY = SQRT_STAGES + 4;

endpackage

FILE: hdl/stereo_downmix_unit.sv
// stereo downmix unit: left, right, mean or signed rms of each stereo pair
`timescale 1ns / 1ps

// Takes one stereo pair on every cycle that start is high; busy is never raised and
// the result stream cannot be held off. Each result appears on rsp_data, marked by
// rsp_strobe, in order, one per cycle at full rate. The latency is set by the integer
// square root, eight stages of two root bits each, plus input, square, sum and output
// registers. The mode is sampled with each pair, so write csr_data only while no pair
// is in flight; csr_ready is always high.
module stereo_downmix_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  sdm_pkg::req_beat_type req_data,
   output logic                 rsp_strobe,
   output sdm_pkg::rsp_beat_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_data
);
   import sdm_pkg::*;

   mix_mode_type mix_mode_ff;

   logic         a_valid_ff;
   req_beat_type a_req_ff;
   mix_mode_type a_mode_ff;

   logic                       b_valid_ff;
   logic        [RAD_W-1:0]    b_sql_ff;
   logic        [RAD_W-1:0]    b_sqr_ff;
   logic        [SAMPLE_W-1:0] b_res_in;
   logic        [SAMPLE_W-1:0] b_res_ff;
   logic                       b_neg_ff;
   logic                       b_rms_ff;
   logic                       b_be_ff;
   logic signed [SAMPLE_W:0]   a_sum;
   logic signed [SAMPLE_W:0]   a_half;
   logic signed [RAD_W-1:0]    a_sql;
   logic signed [RAD_W-1:0]    a_sqr;
   logic        [RAD_W-1:0]    b_sqsum;

   logic                valid_ff [0:SQRT_STAGES];
   logic [RAD_W-1:0]    rad_ff   [0:SQRT_STAGES];
   logic [REM_W-1:0]    rem_ff   [0:SQRT_STAGES];
   logic [ROOT_W-1:0]   root_ff  [0:SQRT_STAGES];
   logic [SAMPLE_W-1:0] res_ff   [0:SQRT_STAGES];
   logic                neg_ff   [0:SQRT_STAGES];
   logic                rms_ff   [0:SQRT_STAGES];
   logic                be_ff    [0:SQRT_STAGES];

   logic [RAD_W-1:0]  rad_in  [1:SQRT_STAGES];
   logic [REM_W-1:0]  rem_in  [1:SQRT_STAGES];
   logic [ROOT_W-1:0] root_in [1:SQRT_STAGES];

   logic                out_valid_ff;
   rsp_beat_type        out_beat_ff;
   logic [SAMPLE_W-1:0] out_mono_in;
   logic [ROOT_W-1:0]   root_fin;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_mode_ff <= MODE_MEAN;
      end else if (csr_valid && csr_ready) begin
         mix_mode_ff <= mix_mode_type'(csr_data);
      end
   end

   // control: valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         a_valid_ff   <= start && !busy;
         b_valid_ff   <= a_valid_ff;
         valid_ff[0]  <= b_valid_ff;
         for (int k = 1; k <= SQRT_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         out_valid_ff <= valid_ff[SQRT_STAGES];
      end
   end

   // stage b: squares and the simple modes
   always_comb begin
      a_sum  = {a_req_ff.left_sample[SAMPLE_W-1], a_req_ff.left_sample}
             + {a_req_ff.right_sample[SAMPLE_W-1], a_req_ff.right_sample};
      a_half = (a_sum + {{SAMPLE_W{1'b0}}, a_sum[SAMPLE_W]}) >>> 1;
      a_sql  = RAD_W'(a_req_ff.left_sample) * RAD_W'(a_req_ff.left_sample);
      a_sqr  = RAD_W'(a_req_ff.right_sample) * RAD_W'(a_req_ff.right_sample);
      case (a_mode_ff)
         MODE_LEFT:  b_res_in = a_req_ff.left_sample;
         MODE_RIGHT: b_res_in = a_req_ff.right_sample;
         MODE_MEAN:  b_res_in = a_half[SAMPLE_W-1:0];
         default:    b_res_in = '0;
      endcase
   end

   assign b_sqsum = b_sql_ff + b_sqr_ff;

   // root stages, two result bits each
   always_comb begin
      logic [REM_W-1:0]  rem;
      logic [REM_W-1:0]  trial;
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
         rem  = rem_ff[k-1];
         rad  = rad_ff[k-1];
         root = root_ff[k-1];
         for (int j = 0; j < 2; j++) begin
            rem   = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
            rad   = {rad[RAD_W-3:0], 2'b00};
            trial = {1'b0, root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               root = {root[ROOT_W-2:0], 1'b0};
            end
         end
         rem_in[k]  = rem;
         rad_in[k]  = rad;
         root_in[k] = root;
      end
   end

   always_comb begin
      root_fin = root_ff[SQRT_STAGES];
      if (!rms_ff[SQRT_STAGES]) begin
         out_mono_in = res_ff[SQRT_STAGES];
      end else if (neg_ff[SQRT_STAGES]) begin
         out_mono_in = ~root_fin + 1'b1;
      end else begin
         out_mono_in = root_fin;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      a_req_ff  <= req_data;
      a_mode_ff <= mix_mode_ff;

      b_sql_ff <= a_sql;
      b_sqr_ff <= a_sqr;
      b_res_ff <= b_res_in;
      b_neg_ff <= a_sum[SAMPLE_W];
      b_rms_ff <= (a_mode_ff == MODE_RMS);
      b_be_ff  <= a_req_ff.block_end;

      rad_ff[0]  <= {1'b0, b_sqsum[RAD_W-1:1]};
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      res_ff[0]  <= b_res_ff;
      neg_ff[0]  <= b_neg_ff;
      rms_ff[0]  <= b_rms_ff;
      be_ff[0]   <= b_be_ff;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
         rad_ff[k]  <= rad_in[k];
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         res_ff[k]  <= res_ff[k-1];
         neg_ff[k]  <= neg_ff[k-1];
         rms_ff[k]  <= rms_ff[k-1];
         be_ff[k]   <= be_ff[k-1];
      end

      out_beat_ff.mono_sample   <= out_mono_in;
      out_beat_ff.block_end_out <= be_ff[SQRT_STAGES];
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_data   = out_beat_ff;

endmodule

FILE: hdl/sdm_checker.sv
// port checker for the stereo downmix unit, bound into every stereo_downmix_unit instance
`timescale 1ns / 1ps
`include "stereo_downmix_unit_macros.svh"

module sdm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input sdm_pkg::req_beat_type req_data,
   input logic                  rsp_strobe,
   input sdm_pkg::rsp_beat_type rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [1:0]            csr_data
);
   import sdm_pkg::*;

   logic accept;
   assign accept = start && !busy;

   `SDM_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_strobe, "beat after reset")
   `SDM_ASSERT_NOW(a_beat_has_item, clock, reset, rsp_strobe,
      $past(accept, PIPE_LATENCY), "beat without item")
   `SDM_ASSERT_NOW(a_item_has_beat, clock, reset,
      $past(accept, PIPE_LATENCY) && !$past(reset, PIPE_LATENCY - 1), rsp_strobe,
      "item lost")
   `SDM_ASSERT_NOW(a_block_end_kept, clock, reset, rsp_strobe,
      rsp_data.block_end_out == $past(req_data.block_end, PIPE_LATENCY), "block end changed")

endmodule

bind stereo_downmix_unit sdm_checker u_sdm_checker (.*);

FILE: tb/sv/stereo_downmix_checker.sv
// checker for the stereo downmix unit: predicts each mono beat and compares it
`timescale 1ns / 1ps

module stereo_downmix_checker
   import sdm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_beat_type req_data,
   input  logic         rsp_strobe,
   input  rsp_beat_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_data,
   output int           mismatch_count,
   output int           outstanding
);

   localparam int REPORT_LIMIT = 10;

   mix_mode_type current_mode = MODE_MEAN;
   rsp_beat_type mono_expected_q [$];
   int           failures = 0;

   assign mismatch_count = failures;

   function automatic longint floor_root(input longint radicand);
      longint root;
      longint trial;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root;
   endfunction

   function automatic rsp_beat_type downmix_pair(input mix_mode_type mode,
                                                 input req_beat_type pair);
      rsp_beat_type beat;
      int           l;
      int           r;
      int           total;
      int           magnitude;
      int           y;
      longint       energy;
      l     = $signed(pair.left_sample);
      r     = $signed(pair.right_sample);
      total = l + r;
      case (mode)
         MODE_LEFT: begin
            y = l;
         end
         MODE_RIGHT: begin
            y = r;
         end
         MODE_MEAN: begin
            // integer division truncates toward zero
            y = total / 2;
         end
         default: begin
            energy    = (longint'(l) * l + longint'(r) * r) >> 1;
            magnitude = int'(floor_root(energy));
            // a zero sum keeps the positive sign
            y = (total < 0) ? -magnitude : magnitude;
         end
      endcase
      beat.mono_sample   = y[15:0];
      beat.block_end_out = pair.block_end;
      return beat;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type expected_beat;
      if (reset) begin
         current_mode = MODE_MEAN;
         mono_expected_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (mono_expected_q.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("unexpected result beat: mono %0d end %0b",
                           rsp_data.mono_sample, rsp_data.block_end_out);
               failures = failures + 1;
            end else begin
               expected_beat = mono_expected_q.pop_front();
               if (rsp_data.mono_sample !== expected_beat.mono_sample ||
                   rsp_data.block_end_out !== expected_beat.block_end_out) begin
                  if (failures < REPORT_LIMIT)
                     $display("mismatch: expected mono %0d end %0b, got mono %0d end %0b",
                              expected_beat.mono_sample, expected_beat.block_end_out,
                              rsp_data.mono_sample, rsp_data.block_end_out);
                  failures = failures + 1;
               end
            end
         end
         if (start && !busy) mono_expected_q.push_back(downmix_pair(current_mode, req_data));
         if (csr_valid && csr_ready) current_mode = mix_mode_type'(csr_data);
      end
      outstanding <= mono_expected_q.size();
   end

endmodule

FILE: tb/sv/stereo_downmix_unit_tb.sv
// testbench top for the stereo downmix unit: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module stereo_downmix_unit_tb;
   import sdm_pkg::*;

   localparam int WATCHDOG_LIMIT = 200;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 50;
   localparam int CALM_PHASE     = 5;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_beat_type req_data;
   logic         rsp_strobe;
   rsp_beat_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;
   int           mismatch_count;
   int           outstanding;
   int           idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   stereo_downmix_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   stereo_downmix_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("stereo_downmix_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(0, 8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic last, input bit calm);
      int gap;
      if (!calm && $urandom_range(0, 99) < 6) begin
         start <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_data <= '{l, r, last};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_pipe();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_mode(input mix_mode_type mode);
      int gap;
      drain_pipe();
      if ($urandom_range(0, 99) < 13) begin
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      csr_data  <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_corner_pairs();
      // both at the negative limit: largest rms magnitude
      send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
      send_pair(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
      send_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
      send_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      // odd negative sum truncates toward zero
      send_pair(-16'sd3, 16'sd0, 1'b0, 1'b0);
      // zero sum keeps a positive rms
      send_pair(16'sd1, -16'sd1, 1'b1, 1'b0);
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= MODE_MEAN;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset mode first, then every other mode
      run_corner_pairs();
      set_mode(MODE_LEFT);
      run_corner_pairs();
      set_mode(MODE_RIGHT);
      run_corner_pairs();
      set_mode(MODE_RMS);
      run_corner_pairs();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 4)
            set_mode(mix_mode_type'(phase[1:0]));
         else
            set_mode(mix_mode_type'(2'($urandom_range(0, 3))));
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_pair(random_sample(), random_sample(), $urandom_range(0, 7) == 0,
                      phase == CALM_PHASE);
      end

      drain_pipe();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("stereo_downmix_unit verification clean");
      end else begin
         $display("stereo_downmix_unit verification failed");
      end
      $finish;
   end

endmodule
